FILE: design/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: design/crsr_pkg.sv
// ----------------------------------------------------------------------------
// crsr_pkg
// shared types and constants of the span rasterizer
// ----------------------------------------------------------------------------
package crsr_pkg;
    localparam logic [1:0] FUNC_OUTLINE = 2'd0;
    localparam logic [1:0] FUNC_FILL    = 2'd1;
    localparam logic [1:0] FUNC_RECT    = 2'd2;
    localparam logic [1:0] FUNC_STEP    = 2'd3;

    localparam int OUT_WIDTH = 12;

    // primitive being drawn
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_OUTLINE = 4'b0010,
        MODE_FILL    = 4'b0100,
        MODE_RECT    = 4'b1000
    } mode_t;

    // command kinds from front to back
    localparam logic [1:0] CMD_START_OUT  = 2'd0;
    localparam logic [1:0] CMD_START_FILL = 2'd1;
    localparam logic [1:0] CMD_STEP       = 2'd2;
    localparam logic [1:0] CMD_RECT_ROW   = 2'd3;

    localparam logic [7:0] RGB_MAX = 8'd255;

    // 8-bit channel to 3 bits, (v*7+127)/255
    function automatic logic [2:0] to3(input logic [7:0] v);
        logic [10:0] t;
        logic [2:0] q;
        t = {3'd0, v} * 11'd7 + 11'd127;
        q = 3'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (t >= 11'(k * 255))
                q = 3'(k);
        end
        return q;
    endfunction

    // 8-bit channel to 2 bits, (v+42)/85
    function automatic logic [1:0] to2(input logic [7:0] v);
        logic [8:0] t;
        logic [1:0] q;
        t = {1'b0, v} + 9'd42;
        q = 2'd0;
        for (int k = 1; k < 4; k++)
        begin
            if (t >= 9'(k * 85))
                q = 2'(k);
        end
        return q;
    endfunction

    function automatic logic [7:0] to332(input logic [23:0] rgb);
        return {to3(rgb[23:16]), to3(rgb[15:8]), to2(rgb[7:0])};
    endfunction
endpackage

FILE: design/crsr_if.sv
// ----------------------------------------------------------------------------
// crsr_in_if / crsr_out_if
// valid/ready channels of the span rasterizer
// ----------------------------------------------------------------------------
interface crsr_in_if #(parameter int COORD_WIDTH = 10, parameter int RADIUS_WIDTH = 9);
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [COORD_WIDTH-1:0]  pos_x;
    logic [COORD_WIDTH-1:0]  pos_y;
    logic [RADIUS_WIDTH-1:0] radius;
    logic [COORD_WIDTH-1:0]  end_x;
    logic [COORD_WIDTH-1:0]  end_y;
    modport source (output valid, func, pos_x, pos_y, radius, end_x, end_y, input ready);
    modport sink (input valid, func, pos_x, pos_y, radius, end_x, end_y, output ready);
endinterface

interface crsr_out_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] row;
    logic signed [11:0] left_col;
    logic signed [11:0] right_col;
    logic [7:0]        color;
    logic              last;
    logic              done_res;
    modport source (output valid, row, left_col, right_col, color, last, done_res,
                    input ready);
    modport sink (input valid, row, left_col, right_col, color, last, done_res,
                  output ready);
endinterface

FILE: design/crsr_front.sv
// ----------------------------------------------------------------------------
// crsr_front
// accepts words, keeps the primitive state and emits at most one command per word
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module crsr_front #(
    parameter int CW = 10,
    parameter int RW = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    crsr_in_if.sink        in_ch,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output logic [1:0]     cmd_kind,
    output logic [CW-1:0]  cmd_cx,
    output logic [CW-1:0]  cmd_cy,
    output logic [CW-1:0]  cmd_i,
    output logic [CW-1:0]  cmd_e,
    output logic [CW-1:0]  cmd_e2,
    output logic           cmd_dec,
    output logic           cmd_wide,
    output logic [CW-1:0]  cmd_r,
    output logic           cmd_done
);
    // square terms up to (2^CW)^2
    localparam int SW = 2 * CW + 2;
    // 0.707 in 32-bit fixed point, rounded up so the floor matches r*707/1000
    localparam logic [31:0] SCALE_707 = 32'd3036541879;

    crsr_pkg::mode_t mode_reg, mode_next;
    logic [CW-1:0] cx_reg, cy_reg, idx_reg, lim_reg, ext_reg;
    logic [SW-1:0] sq_reg;
    logic [CW-1:0] rl_reg, rr_reg, rb_reg;

    logic          acc;
    logic          emit;
    logic [SW-1:0] ii, ee;
    logic [CW-1:0] r_ext;
    logic [RW+31:0] r_scaled;

    logic [1:0]    cmd_kind_next;
    logic [CW-1:0] cmd_cx_next, cmd_cy_next, cmd_e_next, cmd_r_next;
    logic          cmd_wide_next, cmd_done_next;

    assign in_ch.ready = !cmd_valid || cmd_ready;
    assign acc = in_ch.valid && in_ch.ready;
    assign r_ext = CW'(in_ch.radius);
    assign r_scaled = (RW + 32)'(in_ch.radius) * (RW + 32)'(SCALE_707);

    assign ii = SW'(idx_reg) * SW'(idx_reg);
    assign ee = SW'(ext_reg) * SW'(ext_reg);

    logic          over;
    logic [CW-1:0] e_new;
    assign over = (ii + ee) > sq_reg;
    assign e_new = (over && ext_reg != '0) ? ext_reg - 1'b1 : ext_reg;

    logic cmd_valid_reg;
    assign cmd_valid = cmd_valid_reg;

    always_comb
    begin
        mode_next = mode_reg;
        emit = 1'b0;
        cmd_kind_next = crsr_pkg::CMD_STEP;
        cmd_cx_next = cx_reg;
        cmd_cy_next = cy_reg;
        cmd_e_next = ext_reg;
        cmd_wide_next = 1'b0;
        cmd_r_next = '0;
        cmd_done_next = 1'b0;
        case (in_ch.func)
            crsr_pkg::FUNC_OUTLINE:
            begin
                mode_next = crsr_pkg::MODE_OUTLINE;
                emit = 1'b1;
                cmd_kind_next = crsr_pkg::CMD_START_OUT;
                cmd_cx_next = in_ch.pos_x;
                cmd_cy_next = in_ch.pos_y;
                cmd_e_next = r_ext;
            end
            crsr_pkg::FUNC_FILL:
            begin
                mode_next = crsr_pkg::MODE_FILL;
                emit = 1'b1;
                cmd_kind_next = crsr_pkg::CMD_START_FILL;
                cmd_cx_next = in_ch.pos_x;
                cmd_cy_next = in_ch.pos_y;
                cmd_e_next = r_ext;
            end
            crsr_pkg::FUNC_RECT:
            begin
                cmd_kind_next = crsr_pkg::CMD_RECT_ROW;
                if (in_ch.pos_x > in_ch.end_x || in_ch.pos_y > in_ch.end_y)
                    mode_next = crsr_pkg::MODE_IDLE;
                else
                    mode_next = crsr_pkg::MODE_RECT;
            end
            default:
            begin
                if (mode_reg == crsr_pkg::MODE_OUTLINE || mode_reg == crsr_pkg::MODE_FILL)
                begin
                    emit = 1'b1;
                    cmd_wide_next = (mode_reg == crsr_pkg::MODE_FILL) && (ext_reg > lim_reg);
                    cmd_r_next = (mode_reg == crsr_pkg::MODE_FILL) ? CW'(1) : CW'(0);
                    cmd_done_next = idx_reg >= lim_reg;
                    if (idx_reg >= lim_reg)
                        mode_next = crsr_pkg::MODE_IDLE;
                end
                else if (mode_reg == crsr_pkg::MODE_RECT)
                begin
                    emit = 1'b1;
                    cmd_kind_next = crsr_pkg::CMD_RECT_ROW;
                    cmd_cx_next = rl_reg;
                    cmd_e_next = rr_reg;
                    cmd_done_next = idx_reg >= rb_reg;
                    if (idx_reg >= rb_reg)
                        mode_next = crsr_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= crsr_pkg::MODE_IDLE;
            cmd_valid_reg <= 1'b0;
            cx_reg <= '0; cy_reg <= '0; idx_reg <= '0; lim_reg <= '0; ext_reg <= '0;
            sq_reg <= '0; rl_reg <= '0; rr_reg <= '0; rb_reg <= '0;
        end
        else
        begin
            if (acc && emit)
                cmd_valid_reg <= 1'b1;
            else if (cmd_ready)
                cmd_valid_reg <= 1'b0;
            if (acc)
            begin
                mode_reg <= mode_next;
                cmd_kind <= cmd_kind_next;
                cmd_cx <= cmd_cx_next;
                cmd_cy <= cmd_cy_next;
                cmd_i <= idx_reg;
                cmd_e <= cmd_e_next;
                cmd_e2 <= e_new;
                cmd_dec <= over;
                cmd_wide <= cmd_wide_next;
                cmd_r <= cmd_r_next;
                cmd_done <= cmd_done_next;
                case (in_ch.func)
                    crsr_pkg::FUNC_OUTLINE, crsr_pkg::FUNC_FILL:
                    begin
                        cx_reg <= in_ch.pos_x;
                        cy_reg <= in_ch.pos_y;
                        idx_reg <= CW'(1);
                        lim_reg <= CW'(r_scaled[RW+31:32]) + 1'b1;
                        sq_reg <= SW'(r_ext) * SW'(r_ext) + SW'(r_ext >> 1);
                        ext_reg <= r_ext;
                    end
                    crsr_pkg::FUNC_RECT:
                    begin
                        rl_reg <= in_ch.pos_x;
                        rr_reg <= in_ch.end_x;
                        rb_reg <= in_ch.end_y;
                        idx_reg <= in_ch.pos_y;
                    end
                    default:
                    begin
                        if (mode_reg == crsr_pkg::MODE_RECT)
                            idx_reg <= idx_reg + 1'b1;
                        else if (mode_reg == crsr_pkg::MODE_OUTLINE ||
                                 mode_reg == crsr_pkg::MODE_FILL)
                        begin
                            ext_reg <= e_new;
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    `ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && !cmd_ready, cmd_valid)
    `ASSERT_IMPLY(a_no_acc_full, clk, rst_n, cmd_valid && !cmd_ready, !in_ch.ready)
    `ASSERT_NEXT(a_idle_step, clk, rst_n,
                 acc && in_ch.func == crsr_pkg::FUNC_STEP && mode_reg == crsr_pkg::MODE_IDLE,
                 mode_reg == crsr_pkg::MODE_IDLE)
endmodule

FILE: design/crsr_back.sv
// ----------------------------------------------------------------------------
// crsr_back
// expands one command into its spans, one span per cycle while the output is free
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module crsr_back #(
    parameter int CW = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [23:0]    rgb,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  logic [1:0]     cmd_kind,
    input  logic [CW-1:0]  cmd_cx,
    input  logic [CW-1:0]  cmd_cy,
    input  logic [CW-1:0]  cmd_i,
    input  logic [CW-1:0]  cmd_e,
    input  logic [CW-1:0]  cmd_e2,
    input  logic           cmd_dec,
    input  logic           cmd_wide,
    input  logic [CW-1:0]  cmd_r,
    input  logic           cmd_done,
    crsr_out_if.source     out_ch
);
    localparam int OW = crsr_pkg::OUT_WIDTH;

    logic          busy_reg;
    logic [4:0]    slot_reg;
    logic [1:0]    kind_reg;
    logic [CW-1:0] cx_reg, cy_reg, i_reg, e_reg, e2_reg, r_reg;
    logic          dec_reg, wide_reg, done_reg;

    logic signed [OW-1:0] cx, cy, si, e1, e2, rr;
    assign cx = OW'(cx_reg);
    assign cy = OW'(cy_reg);
    assign si = OW'(i_reg);
    assign e1 = OW'(e_reg);
    assign e2 = OW'(e2_reg);
    assign rr = OW'(r_reg);

    // span for the current slot; sv is always set, last_slot bounds the slots
    logic                 sv;
    logic signed [OW-1:0] s_row, s_l, s_r;
    logic [4:0]           last_slot;
    logic [3:0]           n_first;
    logic [4:0]           n_total;

    // one point of the eight-way set; k selects the point
    function automatic void pt(input logic [2:0] k, input logic signed [OW-1:0] xo,
                               input logic signed [OW-1:0] yo,
                               input logic signed [OW-1:0] px, input logic signed [OW-1:0] py,
                               output logic signed [OW-1:0] orow,
                               output logic signed [OW-1:0] ocol);
        case (k)
            3'd0: begin ocol = px + xo; orow = py + yo; end
            3'd1: begin ocol = px - xo; orow = py + yo; end
            3'd2: begin ocol = px + yo; orow = py + xo; end
            3'd3: begin ocol = px + yo; orow = py - xo; end
            3'd4: begin ocol = px + xo; orow = py - yo; end
            3'd5: begin ocol = px - xo; orow = py - yo; end
            3'd6: begin ocol = px - yo; orow = py + xo; end
            default: begin ocol = px - yo; orow = py - xo; end
        endcase
    endfunction

    always_comb
    begin
        logic signed [OW-1:0] prow, pcol, yv;
        logic [4:0] sub;
        logic [3:0] nf;
        prow = '0; pcol = '0; yv = '0; sub = '0; nf = '0;
        sv = 1'b0; s_row = '0; s_l = '0; s_r = '0;
        n_first = '0; n_total = '0;
        case (kind_reg)
            crsr_pkg::CMD_START_OUT:
            begin
                n_total = 5'd4;
                case (slot_reg[1:0])
                    2'd0: begin s_row = cy; s_l = cx + e1; end
                    2'd1: begin s_row = cy; s_l = cx - e1; end
                    2'd2: begin s_row = cy + e1; s_l = cx; end
                    default: begin s_row = cy - e1; s_l = cx; end
                endcase
                s_r = s_l;
            end
            crsr_pkg::CMD_START_FILL:
            begin
                n_total = 5'd1;
                s_row = cy; s_l = cx - e1; s_r = cx + e1;
            end
            crsr_pkg::CMD_RECT_ROW:
            begin
                n_total = 5'd1;
                s_row = si; s_l = cx; s_r = e1;
            end
            default:
            begin
                if (r_reg == '0)
                begin
                    // outline step
                    nf = dec_reg ? ((e_reg == '0) ? 4'd4 : 4'd8) : 4'd0;
                    n_first = nf;
                    n_total = 5'(nf) + ((e2_reg == '0) ? 5'd4 : 5'd8);
                    if (slot_reg < 5'(nf))
                    begin
                        yv = e1; sub = slot_reg;
                    end
                    else
                    begin
                        yv = e2; sub = slot_reg - 5'(nf);
                    end
                    pt(sub[2:0], si, yv, cx, cy, prow, pcol);
                    s_row = prow; s_l = pcol; s_r = pcol;
                end
                else
                begin
                    nf = (dec_reg && wide_reg) ? 4'd2 : 4'd0;
                    n_first = nf;
                    n_total = 5'(nf) + 5'd2;
                    if (slot_reg < 5'(nf))
                    begin
                        s_row = slot_reg[0] ? cy - e1 : cy + e1;
                        s_l = cx - si + OW'(1);
                        s_r = cx + si - OW'(1);
                    end
                    else
                    begin
                        s_row = (slot_reg == 5'(nf)) ? cy + si : cy - si;
                        s_l = cx - e2; s_r = cx + e2;
                    end
                end
            end
        endcase
        sv = 1'b1;
        last_slot = n_total - 1'b1;
    end

    logic out_valid_reg;
    logic out_free;
    logic fin;
    logic advance;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign advance = busy_reg && out_free && sv;
    assign fin = busy_reg && out_free && (slot_reg == last_slot);
    assign cmd_ready = !busy_reg || fin;
    assign out_ch.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                out_ch.row <= s_row;
                out_ch.left_col <= s_l;
                out_ch.right_col <= s_r;
                out_ch.color <= crsr_pkg::to332(rgb);
                out_ch.last <= fin;
                out_ch.done_res <= fin && done_reg;
            end
            if (cmd_valid && cmd_ready)
            begin
                busy_reg <= 1'b1;
                slot_reg <= '0;
                kind_reg <= cmd_kind;
                cx_reg <= cmd_cx; cy_reg <= cmd_cy; i_reg <= cmd_i;
                e_reg <= cmd_e; e2_reg <= cmd_e2; r_reg <= cmd_r;
                dec_reg <= cmd_dec; wide_reg <= cmd_wide; done_reg <= cmd_done;
            end
            else if (advance)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (fin)
                    busy_reg <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_IMPLY(a_slot_range, clk, rst_n, busy_reg, slot_reg <= last_slot)
    `ASSERT_IMPLY(a_done_last, clk, rst_n, out_ch.valid && out_ch.done_res, out_ch.last)
endmodule

FILE: design/circle_rect_span_rasterizer.sv
// a word's spans pass the front's command register, the back's command and output registers
// throughput: one span per cycle while the output is free; a circle step gives 2 to 16 spans
// a start gives 1 or 4 spans, a rectangle row 1 span, an idle step none
// reset: rst_n asynchronous active low, clears mode, queue and output valid
// the color register resets to zero
// ----------------------------------------------------------------------------
// circle_rect_span_rasterizer
// span rasterizer for circles and rectangles, front classifier and span back end
// ----------------------------------------------------------------------------
module circle_rect_span_rasterizer #(
    parameter int COORD_WIDTH = 10,
    parameter int RADIUS_WIDTH = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    crsr_in_if.sink     in_ch,
    crsr_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = COORD_WIDTH;

    // color register
    logic [23:0] rgb_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, rgb_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rgb_reg <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            rgb_reg <= pwdata[23:0];
    end

    // command word between front and back
    logic          cmd_valid, cmd_ready, cmd_dec, cmd_wide, cmd_done;
    logic [1:0]    cmd_kind;
    logic [CW-1:0] cmd_cx, cmd_cy, cmd_i, cmd_e, cmd_e2, cmd_r;

    crsr_front #(.CW(CW), .RW(RADIUS_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_kind(cmd_kind),
        .cmd_cx(cmd_cx), .cmd_cy(cmd_cy), .cmd_i(cmd_i), .cmd_e(cmd_e),
        .cmd_e2(cmd_e2), .cmd_dec(cmd_dec), .cmd_wide(cmd_wide), .cmd_r(cmd_r),
        .cmd_done(cmd_done)
    );

    crsr_back #(.CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .rgb(rgb_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_kind(cmd_kind),
        .cmd_cx(cmd_cx), .cmd_cy(cmd_cy), .cmd_i(cmd_i), .cmd_e(cmd_e),
        .cmd_e2(cmd_e2), .cmd_dec(cmd_dec), .cmd_wide(cmd_wide), .cmd_r(cmd_r),
        .cmd_done(cmd_done), .out_ch(out_ch)
    );
endmodule

FILE: sim/span_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// span_checker
// watches the draw command and span channels and the color register writes,
// predicts the spans of every accepted command and compares them in order
// ----------------------------------------------------------------------------
module span_checker #(
    parameter logic [1:0] COLOR_ADDR = 2'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    crsr_in_if          cmd_mon,
    crsr_out_if         span_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending
);
    typedef enum logic [1:0] {DRAW_IDLE, DRAW_OUTLINE, DRAW_FILL, DRAW_RECT} draw_mode_t;

    typedef struct packed {
        logic signed [11:0] row;
        logic signed [11:0] left_col;
        logic signed [11:0] right_col;
        logic [7:0]         color;
        logic               last;
        logic               done_res;
    } span_t;

    span_t      span_queue[$];
    logic [23:0] color_rgb;
    draw_mode_t draw_mode;
    int         ctr_x, ctr_y, step_i, step_max, extent, sq_max;
    int         rect_l, rect_r, rect_b;
    int         emitted;

    assign pending = span_queue.size();

    function automatic logic [7:0] pack_332(input logic [23:0] rgb);
        int r3, g3, b2;
        r3 = (int'(rgb[23:16]) * 7 + 127) / 255;
        g3 = (int'(rgb[15:8]) * 7 + 127) / 255;
        b2 = (int'(rgb[7:0]) + 42) / 85;
        return 8'((r3 << 5) | (g3 << 2) | b2);
    endfunction

    function automatic void push_span(input int row, input int lc, input int rc);
        span_t s;
        s.row = 12'(row);
        s.left_col = 12'(lc);
        s.right_col = 12'(rc);
        s.color = pack_332(color_rgb);
        s.last = 1'b0;
        s.done_res = 1'b0;
        span_queue.push_back(s);
        emitted++;
    endfunction

    // eight-way symmetric points, four when the y offset is zero
    function automatic void push_octants(input int xo, input int yo);
        push_span(ctr_y + yo, ctr_x + xo, ctr_x + xo);
        push_span(ctr_y + yo, ctr_x - xo, ctr_x - xo);
        push_span(ctr_y + xo, ctr_x + yo, ctr_x + yo);
        push_span(ctr_y - xo, ctr_x + yo, ctr_x + yo);
        if (yo != 0)
        begin
            push_span(ctr_y - yo, ctr_x + xo, ctr_x + xo);
            push_span(ctr_y - yo, ctr_x - xo, ctr_x - xo);
            push_span(ctr_y + xo, ctr_x - yo, ctr_x - yo);
            push_span(ctr_y - xo, ctr_x - yo, ctr_x - yo);
        end
    endfunction

    function automatic void predict_spans(input logic [1:0] func, input int px, input int py,
                                          input int rad, input int ex, input int ey);
        bit finished;
        finished = 0;
        emitted = 0;
        if (func == crsr_pkg::FUNC_OUTLINE || func == crsr_pkg::FUNC_FILL)
        begin
            ctr_x = px;
            ctr_y = py;
            step_i = 1;
            step_max = rad * 707 / 1000 + 1;
            sq_max = rad * rad + rad / 2;
            extent = rad;
            if (func == crsr_pkg::FUNC_OUTLINE)
            begin
                draw_mode = DRAW_OUTLINE;
                push_span(py, px + rad, px + rad);
                push_span(py, px - rad, px - rad);
                push_span(py + rad, px, px);
                push_span(py - rad, px, px);
            end
            else
            begin
                draw_mode = DRAW_FILL;
                push_span(py, px - rad, px + rad);
            end
        end
        else if (func == crsr_pkg::FUNC_RECT)
        begin
            if (px > ex || py > ey)
                draw_mode = DRAW_IDLE;
            else
            begin
                draw_mode = DRAW_RECT;
                rect_l = px;
                rect_r = ex;
                rect_b = ey;
                step_i = py;
            end
        end
        else if (draw_mode == DRAW_OUTLINE || draw_mode == DRAW_FILL)
        begin
            if (step_i * step_i + extent * extent > sq_max)
            begin
                if (draw_mode == DRAW_OUTLINE)
                    push_octants(step_i, extent);
                else if (extent > step_max)
                begin
                    push_span(ctr_y + extent, ctr_x - step_i + 1, ctr_x + step_i - 1);
                    push_span(ctr_y - extent, ctr_x - step_i + 1, ctr_x + step_i - 1);
                end
                if (extent > 0)
                    extent--;
            end
            if (draw_mode == DRAW_OUTLINE)
                push_octants(step_i, extent);
            else
            begin
                push_span(ctr_y + step_i, ctr_x - extent, ctr_x + extent);
                push_span(ctr_y - step_i, ctr_x - extent, ctr_x + extent);
            end
            if (step_i >= step_max)
            begin
                finished = 1;
                draw_mode = DRAW_IDLE;
            end
            else
                step_i++;
        end
        else if (draw_mode == DRAW_RECT)
        begin
            push_span(step_i, rect_l, rect_r);
            if (step_i >= rect_b)
            begin
                finished = 1;
                draw_mode = DRAW_IDLE;
            end
            else
                step_i++;
        end
        if (emitted > 0)
        begin
            span_queue[$].last = 1'b1;
            span_queue[$].done_res = finished;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t exp_span;
        if (!rst_n)
        begin
            span_queue.delete();
            color_rgb <= '0;
            draw_mode <= DRAW_IDLE;
            ctr_x <= 0;
            ctr_y <= 0;
            step_i <= 0;
            step_max <= 0;
            extent <= 0;
            sq_max <= 0;
            rect_l <= 0;
            rect_r <= 0;
            rect_b <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == COLOR_ADDR)
                color_rgb <= pwdata[23:0];
            if (cmd_mon.valid && cmd_mon.ready)
                predict_spans(cmd_mon.func, int'(cmd_mon.pos_x), int'(cmd_mon.pos_y),
                              int'(cmd_mon.radius), int'(cmd_mon.end_x), int'(cmd_mon.end_y));
            if (span_mon.valid && span_mon.ready)
            begin
                if (span_queue.size() == 0)
                begin
                    $error("span word with no expectation: row %0d", span_mon.row);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_span = span_queue.pop_front();
                    if (span_mon.row !== exp_span.row)
                        $error("row: expected %0d, got %0d", exp_span.row, span_mon.row);
                    if (span_mon.left_col !== exp_span.left_col)
                        $error("left_col: expected %0d, got %0d",
                               exp_span.left_col, span_mon.left_col);
                    if (span_mon.right_col !== exp_span.right_col)
                        $error("right_col: expected %0d, got %0d",
                               exp_span.right_col, span_mon.right_col);
                    if (span_mon.color !== exp_span.color)
                        $error("color: expected %0h, got %0h", exp_span.color, span_mon.color);
                    if (span_mon.last !== exp_span.last)
                        $error("last: expected %0b, got %0b", exp_span.last, span_mon.last);
                    if (span_mon.done_res !== exp_span.done_res)
                        $error("done_res: expected %0b, got %0b",
                               exp_span.done_res, span_mon.done_res);
                    if ({span_mon.row, span_mon.left_col, span_mon.right_col, span_mon.color,
                         span_mon.last, span_mon.done_res} !== exp_span)
                        mismatches <= mismatches + 1;
                end
            end
        end
    end
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives draw commands and color writes into the span rasterizer; a checker
// beside the block predicts and compares every span word
// ----------------------------------------------------------------------------
module testbench;
    localparam logic [1:0] ADDR_DRAW_COLOR = 2'd0;
    localparam int TARGET_WORDS = 470;
    // drain margin after the last span, this is plenty
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          words_sent;
    bit          long_hold;
    bit          hold_armed;

    crsr_in_if  in_ch ();
    crsr_out_if out_ch ();

    circle_rect_span_rasterizer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    span_checker #(.COLOR_ADDR(ADDR_DRAW_COLOR)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_mon    (in_ch),
        .span_mon   (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // hang guard, far above the slowest correct run
    initial
    begin
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

    // span sink: random stall per word, one long hold-off to back the block up
    initial
    begin
        int stall;
        bit calm;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 6);
            if (long_hold)
            begin
                stall = 400;
                long_hold = 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    // one draw word with a random gap in front; returns at a falling edge
    task automatic send_word(input logic [1:0] func, input int px, input int py,
                             input int rad, input int ex, input int ey);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= func;
        in_ch.pos_x <= 10'(px);
        in_ch.pos_y <= 10'(py);
        in_ch.radius <= 9'(rad);
        in_ch.end_x <= 10'(ex);
        in_ch.end_y <= 10'(ey);
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_step();
        send_word(crsr_pkg::FUNC_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // circle start plus a number of loop steps
    task automatic draw_circle(input logic [1:0] func, input int cx, input int cy,
                               input int rad, input int steps);
        send_word(func, cx, cy, rad, $urandom_range(0, 1023), $urandom_range(0, 1023));
        repeat (steps) send_step();
    endtask

    function automatic int loop_count(input int rad);
        return rad * 707 / 1000 + 1;
    endfunction

    // wait for every span, then let a trailing idle step settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_color(input logic [23:0] rgb);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DRAW_COLOR;
        pwdata <= {8'd0, rgb};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly whole primitives with random geometry, some abandoned, some noise
    task automatic random_shape();
        int pick, rad, steps, px, py, ex, ey;
        pick = $urandom_range(0, 99);
        px = $urandom_range(0, 1023);
        py = $urandom_range(0, 1023);
        if (pick < 70)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // wide radius, abandoned after up to 8 steps
                rad = $urandom_range(0, 511);
                steps = $urandom_range(0, 8);
            end
            else
            begin
                rad = $urandom_range(0, 20);
                steps = loop_count(rad);
                if ($urandom_range(0, 6) == 0)
                    steps = $urandom_range(0, steps);
                else if ($urandom_range(0, 4) == 0)
                    steps++;
            end
            draw_circle(pick < 35 ? crsr_pkg::FUNC_OUTLINE : crsr_pkg::FUNC_FILL,
                        px, py, rad, steps);
        end
        else if (pick < 88)
        begin
            ex = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                           : (px + $urandom_range(0, 40)) % 1024;
            ey = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                           : (py + $urandom_range(0, 5)) % 1024;
            send_word(crsr_pkg::FUNC_RECT, px, py, $urandom_range(0, 511), ex, ey);
            steps = (px <= ex && py <= ey) ? ey - py + 1 : 1;
            if (steps > 8)
                steps = $urandom_range(1, 8);
            repeat (steps) send_step();
        end
        else
        begin
            // noise: stray steps, bare starts and rectangles
            send_word(2'($urandom_range(0, 3)), px, py, $urandom_range(0, 511),
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    initial
    begin
        logic [23:0] phase_color [4];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = crsr_pkg::FUNC_STEP;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.radius = '0;
        in_ch.end_x = '0;
        in_ch.end_y = '0;
        words_sent = 0;
        long_hold = 0;
        hold_armed = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset color first, then full white
        send_step();                                   // step with nothing running
        draw_circle(crsr_pkg::FUNC_OUTLINE, 0, 0, 0, 1);         // zero radius
        wait_idle();
        write_color(24'hFFFFFF);
        draw_circle(crsr_pkg::FUNC_OUTLINE, 1023, 1023, 1, 1);
        draw_circle(crsr_pkg::FUNC_FILL, 0, 1023, 511, 3);       // abandoned by the next start
        draw_circle(crsr_pkg::FUNC_OUTLINE, 512, 512, 3, loop_count(3));
        draw_circle(crsr_pkg::FUNC_FILL, 1023, 0, 2, loop_count(2));
        send_word(crsr_pkg::FUNC_RECT, 5, 5, 0, 4, 9);           // empty, left past right
        send_step();
        send_word(crsr_pkg::FUNC_RECT, 5, 9, 0, 8, 4);           // empty, top past bottom
        send_word(crsr_pkg::FUNC_RECT, 0, 0, 511, 1023, 0);      // single full-width row
        send_step();
        send_word(crsr_pkg::FUNC_RECT, 1020, 1021, 0, 1023, 1023);
        repeat (3) send_step();
        send_step();
        wait_idle();

        phase_color[0] = 24'h000000;
        phase_color[1] = 24'($urandom);
        phase_color[2] = 24'h2A557F;
        phase_color[3] = 24'($urandom);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_color(phase_color[ph]);
            while (words_sent < TARGET_WORDS * (ph + 1) / 4)
            begin
                if (ph == 1 && !hold_armed && words_sent >= TARGET_WORDS * 3 / 8)
                begin
                    long_hold = 1;
                    hold_armed = 1;
                end
                random_shape();
            end
            wait_idle();
        end

        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
